>>> hdl/nmsl_pkg.sv
package nmsl_pkg;

    // list geometry
    localparam int CONNECTIONS = 4;
    localparam int LIST_DEPTH  = 23;
    localparam int CONN_W      = $clog2(CONNECTIONS);
    localparam int POS_W       = 5;
    localparam int SEQ_W       = 32;
    localparam int BITMAP_W    = 24;
    localparam int BUILD_SPAN  = BITMAP_W - 1;
    localparam int MEM_DEPTH   = CONNECTIONS * LIST_DEPTH;
    localparam int ADDR_W      = $clog2(MEM_DEPTH);
    localparam int FUNC_W      = 3;
    localparam int STATUS_W    = 2;

    // operation codes
    localparam logic [FUNC_W-1:0] FN_INSERT = 3'd0;
    localparam logic [FUNC_W-1:0] FN_REMOVE = 3'd1;
    localparam logic [FUNC_W-1:0] FN_CLEAR  = 3'd2;
    localparam logic [FUNC_W-1:0] FN_GET    = 3'd3;
    localparam logic [FUNC_W-1:0] FN_BUILD  = 3'd4;

    // status codes
    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
    localparam logic [STATUS_W-1:0] ST_RANGE = 2'd2;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd3;

endpackage

>>> hdl/nmsl_req_if.sv
interface nmsl_req_if
    import nmsl_pkg::*;
;
    logic                valid;
    logic                ready;
    logic [FUNC_W-1:0]   func;
    logic [CONN_W-1:0]   conn;
    logic [SEQ_W-1:0]    seq_in;
    logic [POS_W-1:0]    pos;

    modport source (output valid, output func, output conn, output seq_in, output pos,
                    input ready);
    modport sink   (input valid, input func, input conn, input seq_in, input pos,
                    output ready);
endinterface

>>> hdl/nmsl_rsp_if.sv
interface nmsl_rsp_if
    import nmsl_pkg::*;
;
    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic [SEQ_W-1:0]    seq_out;
    logic [BITMAP_W-1:0] bitmap;
    logic [POS_W-1:0]    count_out;

    modport source (output valid, output status, output seq_out, output bitmap,
                    output count_out, input ready);
    modport sink   (input valid, input status, input seq_out, input bitmap,
                    input count_out, output ready);
endinterface

>>> hdl/nack_missing_seq_list_top.sv
// channel | dir | fields                            | transaction
// req     | in  | func, conn, seq_in, pos           | valid & ready at rising clk
// rsp     | out | status, seq_out, bitmap, count_out | valid & ready at rising clk
//
// one request is worked at a time; each gives exactly one response
// insert, clear, rejected ops: response passes through exec and done; get adds a get state
// remove: exec, then the remove state, which moves each later entry up one place, then done
// build: exec, a first load, then one bitmap offset per cycle from the list ram, then done
// control returns to idle before the next request; a full output register adds stalls
// rst_n clears the entry counts and the control; the list ram has no reset
// a response waiting on rsp does not block the next request from being taken
module nack_missing_seq_list_top
    import nmsl_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    nmsl_req_if.sink          req,
    nmsl_rsp_if.source        rsp
);

    typedef enum logic [6:0] {
        S_IDLE   = 7'b0000001,
        S_EXEC   = 7'b0000010,
        S_GET    = 7'b0000100,
        S_REM    = 7'b0001000,
        S_BLD_LD = 7'b0010000,
        S_BLD    = 7'b0100000,
        S_DONE   = 7'b1000000
    } state_t;

    state_t state_reg, state_next;

    // list ram
    logic [SEQ_W-1:0]  mem [MEM_DEPTH];
    logic              mem_we, mem_re;
    logic [ADDR_W-1:0] mem_waddr, mem_raddr;
    logic [SEQ_W-1:0]  mem_wdata, mem_rdata;

    // per connection entry counts
    logic [POS_W-1:0]  count_reg [CONNECTIONS];
    logic              cnt_we;
    logic [POS_W-1:0]  cnt_wdata;

    // request snapshot
    logic [FUNC_W-1:0] func_reg;
    logic [CONN_W-1:0] conn_reg;
    logic [SEQ_W-1:0]  seq_reg;
    logic [POS_W-1:0]  pos_reg;
    logic [POS_W-1:0]  cnt_reg;
    logic [ADDR_W-1:0] base_reg;

    // remove walk
    logic [POS_W-1:0]  rd_idx_reg, rd_idx_next;
    logic [POS_W-1:0]  wr_idx_reg, wr_idx_next;
    logic              pend_reg, pend_next;

    // build walk
    logic [SEQ_W-1:0]      first_reg, first_next;
    logic [SEQ_W-1:0]      cur_reg, cur_next;
    logic [POS_W-1:0]      nxt_reg, nxt_next;
    logic [POS_W-1:0]      step_reg, step_next;
    logic                  mprev_reg, mprev_next;
    logic [BUILD_SPAN-1:0] map_reg, map_next;
    logic [SEQ_W-1:0]      operand;
    logic                  match;
    logic [POS_W-1:0]      pf_idx;

    // result and response registers
    logic [STATUS_W-1:0] res_status_reg, res_status_next;
    logic [SEQ_W-1:0]    res_seq_reg, res_seq_next;
    logic [BITMAP_W-1:0] res_map_reg, res_map_next;
    logic [POS_W-1:0]    res_count_reg, res_count_next;
    logic                ovalid_reg, ovalid_next;
    logic [STATUS_W-1:0] ostatus_reg;
    logic [SEQ_W-1:0]    oseq_reg;
    logic [BITMAP_W-1:0] omap_reg;
    logic [POS_W-1:0]    ocount_reg;
    logic                can_emit;
    logic                load_out;
    logic                req_fire;

    assign req.ready  = (state_reg == S_IDLE);
    assign req_fire   = req.valid && req.ready;
    assign can_emit   = !ovalid_reg || rsp.ready;
    assign load_out   = (state_reg == S_DONE) && can_emit;

    assign rsp.valid     = ovalid_reg;
    assign rsp.status    = ostatus_reg;
    assign rsp.seq_out   = oseq_reg;
    assign rsp.bitmap    = omap_reg;
    assign rsp.count_out = ocount_reg;

    // build compare: list word held or just fetched after a match
    assign operand = mprev_reg ? mem_rdata : cur_reg;
    assign match   = (nxt_reg < cnt_reg) && ((first_reg + SEQ_W'(step_reg)) == operand);

    // main sequencer
    always_comb
    begin
        state_next      = state_reg;
        mem_we          = 1'b0;
        mem_re          = 1'b0;
        mem_waddr       = base_reg;
        mem_raddr       = base_reg;
        mem_wdata       = seq_reg;
        cnt_we          = 1'b0;
        cnt_wdata       = cnt_reg;
        rd_idx_next     = rd_idx_reg;
        wr_idx_next     = wr_idx_reg;
        pend_next       = pend_reg;
        first_next      = first_reg;
        cur_next        = cur_reg;
        nxt_next        = nxt_reg;
        step_next       = step_reg;
        mprev_next      = mprev_reg;
        map_next        = map_reg;
        pf_idx          = nxt_reg;
        res_status_next = res_status_reg;
        res_seq_next    = res_seq_reg;
        res_map_next    = res_map_reg;
        res_count_next  = res_count_reg;
        ovalid_next     = ovalid_reg;

        if (ovalid_reg && rsp.ready)
        begin
            ovalid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (req_fire)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                res_status_next = ST_OK;
                res_seq_next    = '0;
                res_map_next    = '0;
                res_count_next  = cnt_reg;
                state_next      = S_DONE;
                case (func_reg)
                    FN_INSERT:
                    begin
                        if (cnt_reg < POS_W'(LIST_DEPTH))
                        begin
                            mem_we         = 1'b1;
                            mem_waddr      = base_reg + ADDR_W'(cnt_reg);
                            mem_wdata      = seq_reg;
                            cnt_we         = 1'b1;
                            cnt_wdata      = cnt_reg + 1'b1;
                            res_count_next = cnt_reg + 1'b1;
                        end
                        else
                        begin
                            res_status_next = ST_FULL;
                        end
                    end
                    FN_REMOVE:
                    begin
                        if (cnt_reg == '0)
                        begin
                            res_status_next = ST_EMPTY;
                        end
                        else if (pos_reg >= cnt_reg)
                        begin
                            res_status_next = ST_RANGE;
                        end
                        else
                        begin
                            rd_idx_next = pos_reg + 1'b1;
                            wr_idx_next = pos_reg;
                            pend_next   = 1'b0;
                            state_next  = S_REM;
                        end
                    end
                    FN_CLEAR:
                    begin
                        cnt_we         = 1'b1;
                        cnt_wdata      = '0;
                        res_count_next = '0;
                    end
                    FN_GET:
                    begin
                        if (cnt_reg == '0)
                        begin
                            res_status_next = ST_EMPTY;
                        end
                        else if (pos_reg >= cnt_reg)
                        begin
                            res_status_next = ST_RANGE;
                        end
                        else
                        begin
                            mem_re     = 1'b1;
                            mem_raddr  = base_reg + ADDR_W'(pos_reg);
                            state_next = S_GET;
                        end
                    end
                    FN_BUILD:
                    begin
                        if (cnt_reg == '0)
                        begin
                            res_status_next = ST_EMPTY;
                        end
                        else
                        begin
                            mem_re     = 1'b1;
                            mem_raddr  = base_reg;
                            state_next = S_BLD_LD;
                        end
                    end
                    default:
                    begin
                        res_status_next = ST_OK;
                    end
                endcase
            end
            S_GET:
            begin
                res_seq_next = mem_rdata;
                state_next   = S_DONE;
            end
            S_REM:
            begin
                // fetch the next entry while the previous fetch, entry k+1, is written to k
                if (rd_idx_reg < cnt_reg)
                begin
                    mem_re      = 1'b1;
                    mem_raddr   = base_reg + ADDR_W'(rd_idx_reg);
                    rd_idx_next = rd_idx_reg + 1'b1;
                    pend_next   = 1'b1;
                end
                else
                begin
                    pend_next = 1'b0;
                end
                if (pend_reg)
                begin
                    mem_we      = 1'b1;
                    mem_waddr   = base_reg + ADDR_W'(wr_idx_reg);
                    mem_wdata   = mem_rdata;
                    wr_idx_next = wr_idx_reg + 1'b1;
                end
                if (!(rd_idx_reg < cnt_reg) && !pend_reg)
                begin
                    cnt_we         = 1'b1;
                    cnt_wdata      = cnt_reg - 1'b1;
                    res_count_next = cnt_reg - 1'b1;
                    state_next     = S_DONE;
                end
            end
            S_BLD_LD:
            begin
                first_next = mem_rdata;
                cur_next   = mem_rdata;
                nxt_next   = '0;
                step_next  = '0;
                mprev_next = 1'b0;
                map_next   = '0;
                // prefetch the entry after the first
                pf_idx = (LIST_DEPTH > 1) ? POS_W'(1) : '0;
                mem_re     = 1'b1;
                mem_raddr  = base_reg + ADDR_W'(pf_idx);
                state_next = S_BLD;
            end
            S_BLD:
            begin
                cur_next   = operand;
                nxt_next   = nxt_reg + POS_W'(match);
                mprev_next = match;
                map_next   = {map_reg[BUILD_SPAN-2:0], match};
                step_next  = step_reg + 1'b1;
                // fetch the entry now pending so it is on the read port after a match
                if (nxt_next >= POS_W'(LIST_DEPTH - 1))
                begin
                    pf_idx = POS_W'(LIST_DEPTH - 1);
                end
                else
                begin
                    pf_idx = nxt_next;
                end
                mem_re    = 1'b1;
                mem_raddr = base_reg + ADDR_W'(pf_idx);
                if (step_reg == POS_W'(BUILD_SPAN - 1))
                begin
                    res_map_next = {map_next, 1'b0};
                    state_next   = S_DONE;
                end
            end
            S_DONE:
            begin
                if (can_emit)
                begin
                    ovalid_next = 1'b1;
                    state_next  = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            ovalid_reg <= 1'b0;
            for (int c = 0; c < CONNECTIONS; c++)
            begin
                count_reg[c] <= '0;
            end
        end
        else
        begin
            state_reg  <= state_next;
            ovalid_reg <= ovalid_next;
            if (cnt_we)
            begin
                count_reg[conn_reg] <= cnt_wdata;
            end
        end
    end

    // working and payload registers
    always_ff @(posedge clk)
    begin
        if (req_fire)
        begin
            func_reg <= req.func;
            conn_reg <= req.conn;
            seq_reg  <= req.seq_in;
            pos_reg  <= req.pos;
            cnt_reg  <= count_reg[req.conn];
            base_reg <= ADDR_W'(ADDR_W'(req.conn) * ADDR_W'(LIST_DEPTH));
        end
        rd_idx_reg     <= rd_idx_next;
        wr_idx_reg     <= wr_idx_next;
        pend_reg       <= pend_next;
        first_reg      <= first_next;
        cur_reg        <= cur_next;
        nxt_reg        <= nxt_next;
        step_reg       <= step_next;
        mprev_reg      <= mprev_next;
        map_reg        <= map_next;
        res_status_reg <= res_status_next;
        res_seq_reg    <= res_seq_next;
        res_map_reg    <= res_map_next;
        res_count_reg  <= res_count_next;
        if (load_out)
        begin
            ostatus_reg <= res_status_reg;
            oseq_reg    <= res_seq_reg;
            omap_reg    <= res_map_reg;
            ocount_reg  <= res_count_reg;
        end
    end

    // list ram, one write and one registered read port
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            mem_rdata <= mem[mem_raddr];
        end
    end

    // checks
    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_IDLE) |-> (cnt_reg <= POS_W'(LIST_DEPTH)))
        else $error("entry count past list depth");

    a_no_write_in_read_ops: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_GET || state_reg == S_BLD || state_reg == S_BLD_LD) |-> !mem_we)
        else $error("list ram written during get or build");

    a_emit: assert property (@(posedge clk) disable iff (!rst_n)
        load_out |=> ovalid_reg)
        else $error("finished result not presented");

    a_bit0: assert property (@(posedge clk) disable iff (!rst_n)
        ovalid_reg |-> (omap_reg[0] == 1'b0))
        else $error("bitmap bit 0 set");

endmodule
